// File: design/mmm_pkg.sv
// ----------------------------------------------------------------------------
// Motor mixer package
// Shared widths, register indexes and parameter defaults for the motor mixer.
// ----------------------------------------------------------------------------
package mmm_pkg;

  // Fixed slot count: the block always drives eight motor outputs.
  localparam int NUM_SLOTS = 8;

  // Parameter defaults
  localparam int MOTOR_COUNT_DEF   = 4;
  localparam int SCALE_DIVISOR_DEF = 256;

  // Field widths
  localparam int CMD_W     = 16;  // thrust / roll / pitch / yaw command
  localparam int COEF_W    = 8;   // one mixing coefficient
  localparam int TRIM_W    = 16;  // one trim value
  localparam int OPD_W     = 17;  // command plus trim
  localparam int TERMS     = 4;   // thrust, roll, pitch, yaw
  localparam int PRODUCT_W = 25;  // 8 x 17 signed product
  localparam int SUM_W     = 27;  // sum of four products, signed
  localparam int MAG_W     = 26;  // magnitude of the sum
  localparam int QUO_W     = 27;  // signed quotient per motor
  localparam int ADJ_W     = 30;  // shifted command before clamp
  localparam int OUT_W     = 16;  // motor output
  localparam int LIMIT_W   = 16;  // floor / ceiling
  localparam int COUNT_W   = 32;  // failure counter

  // Configuration port
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int TRIMS_W     = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_ROLL_COEFS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH_COEFS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_YAW_COEFS     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_THRUST_COEFS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIM_VALUES   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_FLOOR   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_CEILING = 3'd6;

  localparam logic [LIMIT_W-1:0] CEILING_RESET = 16'd255;

endpackage

// File: design/multirotor_motor_mixer_unit.sv
// ----------------------------------------------------------------------------
// Multirotor motor mixer
// Mixes thrust, roll, pitch and yaw commands into up to eight motor commands,
// divides by a fixed scale, shifts the set into the floor/ceiling window,
// clamps, and counts items that broke both limits.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-----------------------------------
// in       | input     | in_valid / in_stall | thrust, roll, pitch, yaw, enable
// out      | output    | out_valid/out_stall | motor_out_0..7, saturation_failures
// cfg      | input     | cfg_write           | cfg_index, cfg_data
//
// Six register stages: input, products, magnitude, quotient, min/max, output.
// One item enters per cycle when nothing is stalled.
// The divide is a multiply by a reciprocal of SCALE_DIVISOR, one 26 x 27 bit
// multiplier per motor lane, which sets the depth of the quotient stage.
// A stall on the output only holds stages that are occupied; bubbles close up
// and in_stall rises only when every stage holds an item.
// Synchronous reset clears valids, the failure counter and the configuration, except the ceiling, which resets to 255.
// ----------------------------------------------------------------------------
module multirotor_motor_mixer_unit #(
  parameter int MOTOR_COUNT   = mmm_pkg::MOTOR_COUNT_DEF,
  parameter int SCALE_DIVISOR = mmm_pkg::SCALE_DIVISOR_DEF
) (
  input  logic                                clk,
  input  logic                                rst,

  // configuration write port
  input  logic                                cfg_write,
  input  logic [mmm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mmm_pkg::CFG_DATA_W-1:0]      cfg_data,

  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mmm_pkg::CMD_W-1:0]    thrust_command,
  input  logic signed [mmm_pkg::CMD_W-1:0]    roll_command,
  input  logic signed [mmm_pkg::CMD_W-1:0]    pitch_command,
  input  logic signed [mmm_pkg::CMD_W-1:0]    yaw_command,
  input  logic                                motors_enabled,

  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mmm_pkg::OUT_W-1:0]           motor_out_0,
  output logic [mmm_pkg::OUT_W-1:0]           motor_out_1,
  output logic [mmm_pkg::OUT_W-1:0]           motor_out_2,
  output logic [mmm_pkg::OUT_W-1:0]           motor_out_3,
  output logic [mmm_pkg::OUT_W-1:0]           motor_out_4,
  output logic [mmm_pkg::OUT_W-1:0]           motor_out_5,
  output logic [mmm_pkg::OUT_W-1:0]           motor_out_6,
  output logic [mmm_pkg::OUT_W-1:0]           motor_out_7,
  output logic [mmm_pkg::COUNT_W-1:0]         saturation_failures
);

  localparam int NS    = mmm_pkg::NUM_SLOTS;
  localparam int CW    = mmm_pkg::COEF_W;
  localparam int TW    = mmm_pkg::TRIM_W;
  localparam int OW    = mmm_pkg::OPD_W;
  localparam int PW    = mmm_pkg::PRODUCT_W;
  localparam int SW    = mmm_pkg::SUM_W;
  localparam int MW    = mmm_pkg::MAG_W;
  localparam int QW    = mmm_pkg::QUO_W;
  localparam int AW    = mmm_pkg::ADJ_W;
  localparam int LW    = mmm_pkg::LIMIT_W;
  localparam int NT    = mmm_pkg::TERMS;

  // Lanes that take part in the mix; the rest read zero.
  localparam logic [NS-1:0] LANE_ON = NS'((16'd1 << MOTOR_COUNT) - 16'd1);

  // Reciprocal for exact truncating division of an MW-bit magnitude:
  // q = (x * ceil(2^S / D)) >> S with S = MW + ceil(log2 D).
  localparam int RECIP_SHIFT = MW + $clog2(SCALE_DIVISOR);
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(SCALE_DIVISOR) - 64'd1) / 64'(SCALE_DIVISOR);
  localparam int RECIP_W = MW + 1;
  localparam int DPROD_W = MW + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [mmm_pkg::CFG_DATA_W-1:0] roll_coefs;
  logic [mmm_pkg::CFG_DATA_W-1:0] pitch_coefs;
  logic [mmm_pkg::CFG_DATA_W-1:0] yaw_coefs;
  logic [mmm_pkg::CFG_DATA_W-1:0] thrust_coefs;
  logic [mmm_pkg::TRIMS_W-1:0]    trim_values;
  logic [LW-1:0]                  motor_floor;
  logic [LW-1:0]                  motor_ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_coefs    <= '0;
      pitch_coefs   <= '0;
      yaw_coefs     <= '0;
      thrust_coefs  <= '0;
      trim_values   <= '0;
      motor_floor   <= '0;
      motor_ceiling <= mmm_pkg::CEILING_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mmm_pkg::REG_ROLL_COEFS:    roll_coefs    <= cfg_data;
        mmm_pkg::REG_PITCH_COEFS:   pitch_coefs   <= cfg_data;
        mmm_pkg::REG_YAW_COEFS:     yaw_coefs     <= cfg_data;
        mmm_pkg::REG_THRUST_COEFS:  thrust_coefs  <= cfg_data;
        mmm_pkg::REG_TRIM_VALUES:   trim_values   <= cfg_data[mmm_pkg::TRIMS_W-1:0];
        mmm_pkg::REG_MOTOR_FLOOR:   motor_floor   <= cfg_data[LW-1:0];
        mmm_pkg::REG_MOTOR_CEILING: motor_ceiling <= cfg_data[LW-1:0];
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its successor
  // loads. Bubbles close up under an output stall.
  // --------------------------------------------------------------------------
  logic a_valid, b_valid, c_valid, d_valid, e_valid;
  logic go_a, go_b, go_c, go_d, go_e, go_out;

  assign go_out   = !out_valid || !out_stall;
  assign go_e     = !e_valid || go_out;
  assign go_d     = !d_valid || go_e;
  assign go_c     = !c_valid || go_d;
  assign go_b     = !b_valid || go_c;
  assign go_a     = !a_valid || go_b;
  assign in_stall = !go_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go_a)   a_valid   <= in_valid;
      if (go_b)   b_valid   <= a_valid;
      if (go_c)   c_valid   <= b_valid;
      if (go_d)   d_valid   <= c_valid;
      if (go_e)   e_valid   <= d_valid;
      if (go_out) out_valid <= e_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: input register
  // --------------------------------------------------------------------------
  logic signed [mmm_pkg::CMD_W-1:0] a_thrust, a_roll, a_pitch, a_yaw;
  logic                             a_en;

  always_ff @(posedge clk) begin
    if (go_a) begin
      a_thrust <= thrust_command;
      a_roll   <= roll_command;
      a_pitch  <= pitch_command;
      a_yaw    <= yaw_command;
      a_en     <= motors_enabled;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: fold the trims into the roll/pitch/yaw operands, then one
  // 8 x 17 product per term and lane.
  // --------------------------------------------------------------------------
  logic signed [OW-1:0] opd [NT];
  logic signed [PW-1:0] prod_next [NS][NT];
  logic signed [PW-1:0] b_prod [NS][NT];
  logic                 b_en;

  always_comb begin
    opd[0] = OW'(a_thrust);
    opd[1] = OW'(a_roll)  + OW'($signed(trim_values[0*TW +: TW]));
    opd[2] = OW'(a_pitch) + OW'($signed(trim_values[1*TW +: TW]));
    opd[3] = OW'(a_yaw)   + OW'($signed(trim_values[2*TW +: TW]));
    for (int m = 0; m < NS; m++) begin
      prod_next[m][0] = PW'($signed(thrust_coefs[m*CW +: CW])) * PW'(opd[0]);
      prod_next[m][1] = PW'($signed(roll_coefs[m*CW +: CW]))   * PW'(opd[1]);
      prod_next[m][2] = PW'($signed(pitch_coefs[m*CW +: CW]))  * PW'(opd[2]);
      prod_next[m][3] = PW'($signed(yaw_coefs[m*CW +: CW]))    * PW'(opd[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (go_b) begin
      b_prod <= prod_next;
      b_en   <= a_en;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: sum the four terms, split into sign and magnitude
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] sum_c [NS];
  logic [MW-1:0]        mag_next [NS];
  logic [MW-1:0]        c_mag [NS];
  logic [NS-1:0]        c_neg;
  logic                 c_en;

  always_comb begin
    for (int m = 0; m < NS; m++) begin
      sum_c[m] = SW'(b_prod[m][0]) + SW'(b_prod[m][1])
               + SW'(b_prod[m][2]) + SW'(b_prod[m][3]);
      mag_next[m] = sum_c[m][SW-1] ? MW'(-sum_c[m]) : MW'(sum_c[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (go_c) begin
      c_mag <= mag_next;
      for (int m = 0; m < NS; m++) c_neg[m] <= sum_c[m][SW-1];
      c_en <= b_en;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: divide by SCALE_DIVISOR through the reciprocal, restore sign
  // (truncation toward zero falls out of dividing the magnitude)
  // --------------------------------------------------------------------------
  logic [DPROD_W-1:0]   dprod [NS];
  logic [DPROD_W-1:0]   dshift [NS];
  logic signed [QW-1:0] quo_next [NS];
  logic signed [QW-1:0] d_cmd [NS];
  logic                 d_en;

  always_comb begin
    for (int m = 0; m < NS; m++) begin
      dprod[m]    = DPROD_W'(c_mag[m]) * DPROD_W'(RECIP);
      dshift[m]   = dprod[m] >> RECIP_SHIFT;
      quo_next[m] = c_neg[m] ? -$signed(QW'(dshift[m][MW-1:0]))
                             :  $signed(QW'(dshift[m][MW-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (go_d) begin
      d_cmd <= quo_next;
      d_en  <= c_en;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: minimum and maximum over the active lanes
  // --------------------------------------------------------------------------
  logic signed [QW-1:0] min_next, max_next;
  logic signed [QW-1:0] e_cmd [NS];
  logic signed [QW-1:0] e_min, e_max;
  logic                 e_en;

  always_comb begin
    min_next = d_cmd[0];
    max_next = d_cmd[0];
    for (int m = 1; m < NS; m++) begin
      if (LANE_ON[m] && d_cmd[m] < min_next) min_next = d_cmd[m];
      if (LANE_ON[m] && d_cmd[m] > max_next) max_next = d_cmd[m];
    end
  end

  always_ff @(posedge clk) begin
    if (go_e) begin
      e_cmd <= d_cmd;
      e_min <= min_next;
      e_max <= max_next;
      e_en  <= d_en;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: shift into the window using the pre-shift min/max, clamp,
  // zero unused lanes and disabled items, count double violations.
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] lo_x, hi_x, min_x, max_x, raise, lower;
  logic signed [AW-1:0] adj [NS];
  logic [mmm_pkg::OUT_W-1:0] motor_next [NS];
  logic [mmm_pkg::OUT_W-1:0] motor_q [NS];
  logic under, over, fail;
  logic [mmm_pkg::COUNT_W-1:0] failure_count, failure_count_next;

  always_comb begin
    lo_x  = $signed(AW'(motor_floor));
    hi_x  = $signed(AW'(motor_ceiling));
    min_x = AW'(e_min);
    max_x = AW'(e_max);
    under = min_x < lo_x;
    over  = max_x > hi_x;
    raise = under ? lo_x - min_x : '0;
    lower = over  ? max_x - hi_x : '0;
    fail  = e_en && under && over;
    for (int m = 0; m < NS; m++) begin
      adj[m] = AW'(e_cmd[m]) + raise - lower;
      priority if (!e_en || !LANE_ON[m]) begin
        motor_next[m] = '0;
      end else if (adj[m] > hi_x) begin
        motor_next[m] = motor_ceiling;
      end else if (adj[m] < lo_x) begin
        motor_next[m] = motor_floor;
      end else begin
        motor_next[m] = adj[m][mmm_pkg::OUT_W-1:0];
      end
    end
    failure_count_next = failure_count + mmm_pkg::COUNT_W'(fail);
  end

  always_ff @(posedge clk) begin
    if (go_out && e_valid) begin
      motor_q <= motor_next;
    end
  end

  // The counter doubles as the output field: it moves only when an item
  // enters the output register, so it holds while the output is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      failure_count <= '0;
    end else if (go_out && e_valid) begin
      failure_count <= failure_count_next;
    end
  end

  assign motor_out_0         = motor_q[0];
  assign motor_out_1         = motor_q[1];
  assign motor_out_2         = motor_q[2];
  assign motor_out_3         = motor_q[3];
  assign motor_out_4         = motor_q[4];
  assign motor_out_5         = motor_q[5];
  assign motor_out_6         = motor_q[6];
  assign motor_out_7         = motor_q[7];
  assign saturation_failures = failure_count;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && failure_count != $past(failure_count)
      |-> failure_count == $past(failure_count) + mmm_pkg::COUNT_W'(1))
    else $error("failure counter moved by more than one");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> a_valid && b_valid && c_valid && d_valid && e_valid
                 && out_valid && out_stall)
    else $error("input stalled while the pipeline has a free stage");

  a_out_from_e: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(e_valid))
    else $error("output became valid without an item in the min/max stage");

  a_count_held: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(out_valid && out_stall) |-> $stable(failure_count))
    else $error("failure counter moved while the output was held");

  a_last_slot_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !LANE_ON[NS-1] |-> motor_q[NS-1] == '0)
    else $error("unused motor slot drove a nonzero command");

endmodule
